// ===== rtl/mh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh_pkg: shared types and constants of the magnetometer heading block
// Widths, CORDIC angle table, register codes and the beat structs that move
// down the processing chain.
// ----------------------------------------------------------------------------
package mh_pkg;

    // Iteration count and angle precision
    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 8;

    localparam int TABLE_LEN  = 24;
    localparam int TABLE_FRAC = 24;
    localparam int STEP_W     = $clog2(TABLE_LEN);

    // Raw sample and scaling (value * 15 / 100 == value * 3 / 20)
    localparam int RAW_W       = 16;
    localparam int MAG_W       = RAW_W + 1;
    localparam int SCALE_SHIFT = 20;
    localparam logic [15:0] SCALE_MUL = 16'd52429; // ceil(2^20 / 20)
    localparam int PROD_W      = MAG_W + 16;
    localparam int QUOT_W      = PROD_W - SCALE_SHIFT;
    localparam int AXIS_W      = QUOT_W + 1;

    // CORDIC datapath
    localparam int PRESCALE_SHIFT = 8;
    localparam int XY_W           = 25;
    localparam int Z_W            = ANGLE_FRAC_BITS + 10;
    localparam int RIGHT_ANGLE    = 90 * (1 << ANGLE_FRAC_BITS);

    // Declination alignment to the angle format
    localparam int DECL_W      = 16;
    localparam int DECL_SHL    = (ANGLE_FRAC_BITS >= 8) ? ANGLE_FRAC_BITS - 8 : 0;
    localparam int DECL_SHR    = (ANGLE_FRAC_BITS >= 8) ? 0 : 8 - ANGLE_FRAC_BITS;
    localparam int DECL_WIDE_W = DECL_W + DECL_SHL;

    // Whole degrees and final wrap
    localparam int WHOLE_W    = Z_W + 1 - ANGLE_FRAC_BITS;
    localparam int OFFSET_W   = 10;
    localparam int TOTAL_W    = 12;
    localparam int HEADING_W  = 9;
    localparam int FULL_TURN  = 360;
    localparam int MOD_BIAS   = 3 * FULL_TURN;

    // Register reset values
    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = -10'sd240;
    localparam logic signed [DECL_W-1:0]   DECL_RESET   = 16'sd1467;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    typedef enum logic {
        REG_OFFSET = 1'b0,
        REG_DECL   = 1'b1
    } reg_idx_t;

    // atan(2^-i) in degrees, Q24, rounded
    localparam int ATAN_Q24 [TABLE_LEN] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic valid;
        logic ready;
        logic ovf;
    } side_t;

    typedef struct packed {
        side_t                   side;
        logic                    zero;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
    } cell_t;

    function automatic logic signed [Z_W-1:0] cordic_angle(input logic [STEP_W-1:0] step);
        int v;
        v = (ATAN_Q24[step] + (1 << (TABLE_FRAC - ANGLE_FRAC_BITS - 1)))
            >>> (TABLE_FRAC - ANGLE_FRAC_BITS);
        return Z_W'(v);
    endfunction

endpackage

// ===== rtl/mh_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh_front: sample conditioning
// Negates and scales both axes by 15/100 toward zero, then prescales and
// folds the vector into the right half plane for the CORDIC chain.
// ----------------------------------------------------------------------------
module mh_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  mh_pkg::side_t                     side_in,
    input  logic signed [mh_pkg::RAW_W-1:0]   x_field,
    input  logic signed [mh_pkg::RAW_W-1:0]   y_field,
    output mh_pkg::cell_t                     cell_out
);
    import mh_pkg::*;

    logic [RAW_W-1:0]         raw [2];
    logic [RAW_W-1:0]         neg_raw [2];
    logic [MAG_W-1:0]         mag [2];
    logic [QUOT_W-1:0]        quot [2];

    side_t                    s1_side_reg, s2_side_reg, s3_side_reg;
    logic [1:0]               s1_sign_next, s1_sign_reg, s2_sign_reg;
    logic [MAG_W-1:0]         s1_mag3_next [2];
    logic [MAG_W-1:0]         s1_mag3_reg [2];
    logic [PROD_W-1:0]        s2_prod_next [2];
    logic [PROD_W-1:0]        s2_prod_reg [2];
    logic signed [AXIS_W-1:0] s3_axis_next [2];
    logic signed [AXIS_W-1:0] s3_axis_reg [2];

    logic signed [XY_W-1:0]   xs, ys;
    cell_t                    cell_next, cell_reg;

    assign raw[0] = x_field;
    assign raw[1] = y_field;

    // Negate with wrap, take magnitude, times three
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            neg_raw[k]      = -raw[k];
            s1_sign_next[k] = neg_raw[k][RAW_W-1];
            mag[k]          = neg_raw[k][RAW_W-1]
                            ? MAG_W'((MAG_W'(1) << RAW_W) - {1'b0, neg_raw[k]})
                            : {1'b0, neg_raw[k]};
            s1_mag3_next[k] = MAG_W'(mag[k] * 2'd3);
        end
    end

    // Divide by twenty through the reciprocal
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            s2_prod_next[k] = PROD_W'(s1_mag3_reg[k]) * PROD_W'(SCALE_MUL);
        end
    end

    // Restore the sign
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            quot[k]         = s2_prod_reg[k][PROD_W-1:SCALE_SHIFT];
            s3_axis_next[k] = s2_sign_reg[k] ? -AXIS_W'(quot[k]) : AXIS_W'(quot[k]);
        end
    end

    // Prescale and fold into the right half plane
    always_comb
    begin
        xs             = XY_W'(s3_axis_reg[0]) <<< PRESCALE_SHIFT;
        ys             = XY_W'(s3_axis_reg[1]) <<< PRESCALE_SHIFT;
        cell_next.side = s3_side_reg;
        cell_next.zero = (s3_axis_reg[0] == '0) && (s3_axis_reg[1] == '0);
        cell_next.x    = xs;
        cell_next.y    = ys;
        cell_next.z    = '0;
        if (xs[XY_W-1])
        begin
            if (!ys[XY_W-1])
            begin
                cell_next.x = ys;
                cell_next.y = -xs;
                cell_next.z = Z_W'(RIGHT_ANGLE);
            end
            else
            begin
                cell_next.x = -ys;
                cell_next.y = xs;
                cell_next.z = -Z_W'(RIGHT_ANGLE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_side_reg <= '0;
            s2_side_reg <= '0;
            s3_side_reg <= '0;
            cell_reg    <= '0;
        end
        else if (adv)
        begin
            s1_side_reg <= side_in;
            s2_side_reg <= s1_side_reg;
            s3_side_reg <= s2_side_reg;
            cell_reg    <= cell_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sign_reg  <= s1_sign_next;
            s2_sign_reg  <= s1_sign_reg;
            s1_mag3_reg  <= s1_mag3_next;
            s2_prod_reg  <= s2_prod_next;
            s3_axis_reg  <= s3_axis_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ===== rtl/mh_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh_cordic_cell: one vectoring CORDIC iteration
// Rotates the vector toward the x axis by atan(2^-step) and accumulates the
// angle; registered output feeds the next cell.
// ----------------------------------------------------------------------------
module mh_cordic_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic [mh_pkg::STEP_W-1:0]   step,
    input  mh_pkg::cell_t               cell_in,
    output mh_pkg::cell_t               cell_out
);
    import mh_pkg::*;

    logic signed [XY_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  angle;
    cell_t                  cell_next, cell_reg;

    always_comb
    begin
        dx        = cell_in.y >>> step;
        dy        = cell_in.x >>> step;
        angle     = cordic_angle(step);
        cell_next = cell_in;
        if (!cell_in.y[XY_W-1])
        begin
            cell_next.x = cell_in.x + dx;
            cell_next.y = cell_in.y - dy;
            cell_next.z = cell_in.z + angle;
        end
        else
        begin
            cell_next.x = cell_in.x - dx;
            cell_next.y = cell_in.y + dy;
            cell_next.z = cell_in.z - angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (adv)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ===== rtl/mh_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh_back: heading finish and output register
// Removes declination, truncates to whole degrees, adds the offset, wraps
// into 0..359 and substitutes the held heading on overflow samples.
// ----------------------------------------------------------------------------
module mh_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  mh_pkg::cell_t                         cell_in,
    input  logic signed [mh_pkg::OFFSET_W-1:0]    heading_offset,
    input  logic signed [mh_pkg::DECL_W-1:0]      declination_q8,
    output logic                                  out_valid,
    output logic [mh_pkg::HEADING_W-1:0]          heading_deg,
    output logic                                  error
);
    import mh_pkg::*;

    logic signed [DECL_WIDE_W-1:0] decl_wide;
    logic signed [Z_W:0]           decl_s;
    logic signed [Z_W-1:0]         angle;
    logic signed [Z_W:0]           diff;
    logic [Z_W:0]                  diff_mag;
    logic [WHOLE_W-1:0]            whole_mag;

    side_t                         s5_side_reg;
    logic signed [WHOLE_W-1:0]     s5_whole_next, s5_whole_reg;

    logic signed [WHOLE_W-1:0]     deg;
    logic signed [TOTAL_W-1:0]     biased;
    logic [TOTAL_W-2:0]            folded;
    logic [TOTAL_W-2:0]            wrapped;
    logic                          hold;

    logic                          valid_next, valid_reg;
    logic [HEADING_W-1:0]          heading_next, heading_reg;
    logic                          error_next, error_reg;
    logic [HEADING_W-1:0]          last_heading_next, last_heading_reg;

    // Bearing minus declination, truncated toward zero
    always_comb
    begin
        decl_wide     = (DECL_WIDE_W'(declination_q8) <<< DECL_SHL) >>> DECL_SHR;
        decl_s        = (Z_W+1)'(decl_wide);
        angle         = cell_in.zero ? '0 : cell_in.z;
        diff          = (Z_W+1)'(angle) - decl_s;
        diff_mag      = diff[Z_W] ? -diff : diff;
        whole_mag     = diff_mag[Z_W:ANGLE_FRAC_BITS];
        s5_whole_next = diff[Z_W] ? -whole_mag : whole_mag;
    end

    // Offset and true modulo 360
    always_comb
    begin
        deg    = s5_side_reg.ready ? s5_whole_reg : '0;
        biased = TOTAL_W'(deg) + TOTAL_W'(heading_offset) + TOTAL_W'(MOD_BIAS);
        folded = biased[TOTAL_W-2:0];
        if (folded >= (TOTAL_W-1)'(5 * FULL_TURN))
            wrapped = folded - (TOTAL_W-1)'(5 * FULL_TURN);
        else if (folded >= (TOTAL_W-1)'(4 * FULL_TURN))
            wrapped = folded - (TOTAL_W-1)'(4 * FULL_TURN);
        else if (folded >= (TOTAL_W-1)'(3 * FULL_TURN))
            wrapped = folded - (TOTAL_W-1)'(3 * FULL_TURN);
        else if (folded >= (TOTAL_W-1)'(2 * FULL_TURN))
            wrapped = folded - (TOTAL_W-1)'(2 * FULL_TURN);
        else if (folded >= (TOTAL_W-1)'(FULL_TURN))
            wrapped = folded - (TOTAL_W-1)'(FULL_TURN);
        else
            wrapped = folded;
    end

    // Overflow beats repeat the held heading and leave it untouched
    always_comb
    begin
        hold              = s5_side_reg.ready && s5_side_reg.ovf;
        valid_next        = s5_side_reg.valid;
        last_heading_next = last_heading_reg;
        if (hold)
        begin
            heading_next = last_heading_reg;
            error_next   = 1'b1;
        end
        else
        begin
            heading_next = HEADING_W'(wrapped);
            error_next   = 1'b0;
            if (s5_side_reg.valid)
                last_heading_next = HEADING_W'(wrapped);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_side_reg      <= '0;
            valid_reg        <= 1'b0;
            last_heading_reg <= '0;
        end
        else if (adv)
        begin
            s5_side_reg      <= cell_in.side;
            valid_reg        <= valid_next;
            last_heading_reg <= last_heading_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_whole_reg <= s5_whole_next;
            heading_reg  <= heading_next;
            error_reg    <= error_next;
        end
    end

    assign out_valid   = valid_reg;
    assign heading_deg = heading_reg;
    assign error       = error_reg;

endmodule

// ===== rtl/magnetometer_heading.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_heading: compass heading from raw magnetometer samples
// Scaled axes run through a chain of CORDIC cells for atan2, then
// declination, offset and a wrap into 0..359 give the heading.
// ----------------------------------------------------------------------------
// Stages: from sample beat to heading beat, four conditioning stages, one cell
//   per iteration and two finish stages.
// Throughput: one sample beat per cycle; the chain is a single shift line, so
//   a held heading beat freezes every stage and stalls the sample side.
// Reset: asynchronous; chain emptied, held heading cleared to 0, offset set
//   to -240 and declination to 1467 (Q8 degrees).
// ----------------------------------------------------------------------------
module magnetometer_heading (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample channel
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic                                data_ready,
    input  logic signed [mh_pkg::RAW_W-1:0]     x_field,
    input  logic signed [mh_pkg::RAW_W-1:0]     y_field,
    input  logic                                overflow,
    // heading channel
    output logic                                heading_valid,
    input  logic                                heading_stall,
    output logic [mh_pkg::HEADING_W-1:0]        heading_deg,
    output logic                                error,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mh_pkg::ADDR_W-1:0]           paddr,
    input  logic [mh_pkg::DATA_W-1:0]           pwdata,
    output logic [mh_pkg::DATA_W-1:0]           prdata,
    output logic                                pready
);
    import mh_pkg::*;

    logic                          adv;
    side_t                         side_in;
    cell_t                         chain [CORDIC_STEPS+1];

    logic signed [OFFSET_W-1:0]    offset_reg, offset_next;
    logic signed [DECL_W-1:0]      decl_reg, decl_next;
    logic                          wr_en;
    reg_idx_t                      reg_sel;

    // The whole chain moves together unless a finished beat is held at the
    // output; a bubble in the output register never blocks the sample side.
    assign adv          = !(heading_valid && heading_stall);
    assign sample_stall = !adv;

    assign side_in.valid = sample_valid;
    assign side_in.ready = data_ready;
    assign side_in.ovf   = overflow;

    mh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .side_in  (side_in),
        .x_field  (x_field),
        .y_field  (y_field),
        .cell_out (chain[0])
    );

    // One cell per iteration, each with its own fixed shift and angle
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        mh_cordic_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .step     (STEP_W'(i)),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    // Held heading lives beside the output register so overflow beats pick
    // up whatever the previous beat left, whatever the stall pattern.
    mh_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .cell_in        (chain[CORDIC_STEPS]),
        .heading_offset (offset_reg),
        .declination_q8 (decl_reg),
        .out_valid      (heading_valid),
        .heading_deg    (heading_deg),
        .error          (error)
    );

    // Configuration registers; write on the access phase, no wait states
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = reg_idx_t'(paddr[2]);

    always_comb
    begin
        offset_next = offset_reg;
        decl_next   = decl_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_OFFSET: offset_next = pwdata[OFFSET_W-1:0];
                REG_DECL:   decl_next   = pwdata[DECL_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_OFFSET: prdata = DATA_W'(offset_reg);
            REG_DECL:   prdata = DATA_W'(decl_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
            decl_reg   <= DECL_RESET;
        end
        else
        begin
            offset_reg <= offset_next;
            decl_reg   <= decl_next;
        end
    end

endmodule

// ===== rtl/mh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh_checker: port-level checks for the heading block
// Watches the sample, heading and configuration ports over time.
// ----------------------------------------------------------------------------
module mh_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                sample_stall,
    input logic                                heading_valid,
    input logic                                heading_stall,
    input logic [mh_pkg::HEADING_W-1:0]        heading_deg,
    input logic                                error,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [mh_pkg::ADDR_W-1:0]           paddr,
    input logic [mh_pkg::DATA_W-1:0]           pwdata,
    input logic [mh_pkg::DATA_W-1:0]           prdata,
    input logic                                pready
);
    import mh_pkg::*;

    // A held heading beat keeps its payload
    a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        heading_valid && heading_stall |=>
            heading_valid && $stable(heading_deg) && $stable(error))
        else $error("heading beat changed while stalled");

    // Heading always lands in one turn
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        heading_valid |-> heading_deg < HEADING_W'(FULL_TURN))
        else $error("heading outside 0..359");

    // Sample side stalls exactly when a heading beat is held
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall == (heading_valid && heading_stall))
        else $error("sample stall does not follow output hold");

    // Output is empty once reset has been seen at an edge
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !heading_valid)
        else $error("heading beat during reset");

    // Offset write reads back sign-extended
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && !paddr[2]) ##1 !paddr[2] |->
            prdata == DATA_W'($signed($past(pwdata[OFFSET_W-1:0]))))
        else $error("offset register readback mismatch");

endmodule

bind magnetometer_heading mh_checker u_checker (.*);

// ===== tb/heading_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_checker: scoreboard for the magnetometer heading block
// Tracks the register writes, works out the heading for every accepted sample
// beat and compares each heading beat with the oldest heading still due.
// ----------------------------------------------------------------------------
module heading_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    input  logic                               sample_stall,
    input  logic                               data_ready,
    input  logic signed [mh_pkg::RAW_W-1:0]    x_field,
    input  logic signed [mh_pkg::RAW_W-1:0]    y_field,
    input  logic                               overflow,
    input  logic                               heading_valid,
    input  logic                               heading_stall,
    input  logic [mh_pkg::HEADING_W-1:0]       heading_deg,
    input  logic                               error,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [mh_pkg::ADDR_W-1:0]          paddr,
    input  logic [mh_pkg::DATA_W-1:0]          pwdata,
    output int                                 pending,
    output int                                 mismatches
);
    import mh_pkg::*;

    localparam int STEPS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int FRAC  = ANGLE_FRAC_BITS;
    localparam int TURN  = 360;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam int ATAN_DEG_Q24 [24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic [HEADING_W-1:0] deg;
        logic                 err;
    } heading_beat_t;

    logic signed [9:0]     offset_deg;
    logic signed [15:0]    decl_q8;
    logic [HEADING_W-1:0]  held_heading;
    heading_beat_t         headings_due [$];

    // Negate with 16-bit wrap, then scale by 15/100 truncating toward zero
    function automatic int scaled_axis(input logic signed [15:0] raw);
        logic signed [15:0] flipped;
        int                 prod;
        flipped = -raw;
        prod    = int'(flipped) * 15;
        return prod / 100;
    endfunction

    // Vectoring CORDIC: atan2(ys, xs) in degrees with FRAC fraction bits
    function automatic int bearing_q(input int ys, input int xs);
        int xa, ya, za, t, step_angle;
        if (xs == 0 && ys == 0)
            return 0;
        xa = xs * 256;
        ya = ys * 256;
        za = 0;
        if (xa < 0)
        begin
            if (ya >= 0)
            begin
                t  = xa;
                xa = ya;
                ya = -t;
                za = 90 * (1 << FRAC);
            end
            else
            begin
                t  = xa;
                xa = -ya;
                ya = t;
                za = -90 * (1 << FRAC);
            end
        end
        for (int i = 0; i < STEPS; i++)
        begin
            step_angle = (ATAN_DEG_Q24[i] + (1 << (23 - FRAC))) >>> (24 - FRAC);
            if (ya >= 0)
            begin
                t  = xa + (ya >>> i);
                ya = ya - (xa >>> i);
                xa = t;
                za = za + step_angle;
            end
            else
            begin
                t  = xa - (ya >>> i);
                ya = ya + (xa >>> i);
                xa = t;
                za = za - step_angle;
            end
        end
        return za;
    endfunction

    function automatic heading_beat_t predict_heading(input logic rdy,
                                                      input logic signed [15:0] xr,
                                                      input logic signed [15:0] yr,
                                                      input logic ovf);
        heading_beat_t beat;
        int            deg_whole, q, decl_aligned, total;
        deg_whole = 0;
        if (rdy && ovf)
        begin
            beat.deg = held_heading;
            beat.err = 1'b1;
            return beat;
        end
        if (rdy)
        begin
            q = bearing_q(scaled_axis(yr), scaled_axis(xr));
            if (FRAC >= 8)
                decl_aligned = int'(decl_q8) <<< (FRAC - 8);
            else
                decl_aligned = int'(decl_q8) >>> (8 - FRAC);
            q         = q - decl_aligned;
            deg_whole = q / (1 << FRAC);
        end
        total = (deg_whole + int'(offset_deg)) % TURN;
        if (total < 0)
            total = total + TURN;
        held_heading = HEADING_W'(total);
        beat.deg     = held_heading;
        beat.err     = 1'b0;
        return beat;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        heading_beat_t due;
        int            bad;
        if (!rst_n)
        begin
            offset_deg   = -10'sd240;
            decl_q8      = 16'sd1467;
            held_heading = '0;
            headings_due.delete();
            pending    <= 0;
            mismatches <= 0;
        end
        else
        begin
            bad = 0;
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_OFFSET: offset_deg = pwdata[9:0];
                    REG_DECL:   decl_q8    = pwdata[15:0];
                    default:    ;
                endcase
            end
            if (sample_valid && !sample_stall)
                headings_due.push_back(predict_heading(data_ready, x_field, y_field, overflow));
            if (heading_valid && !heading_stall)
            begin
                if (headings_due.size() == 0)
                begin
                    $error("heading beat with nothing due: heading_deg %0d, error %0d",
                           heading_deg, error);
                    bad++;
                end
                else
                begin
                    due = headings_due.pop_front();
                    if (heading_deg !== due.deg)
                    begin
                        $error("heading_deg mismatch: expected %0d, actual %0d",
                               due.deg, heading_deg);
                        bad++;
                    end
                    if (error !== due.err)
                    begin
                        $error("error mismatch: expected %0d, actual %0d", due.err, error);
                        bad++;
                    end
                end
            end
            if (bad != 0)
                mismatches <= mismatches + bad;
            pending <= headings_due.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the magnetometer heading block
// Resets the block, writes the offset and declination registers between
// phases, and drives directed then random sample beats with random gaps and
// back-pressure. The checker beside the block predicts and compares; this
// module only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import mh_pkg::*;

    // Generous bound: ~1000 beats, each worst case a long gap, a long stall
    // and the full pipeline, several times over
    localparam int CYCLE_LIMIT  = 400000;
    // Pipeline is CORDIC_STEPS + 6 deep; give it room to empty
    localparam int DRAIN_CYCLES = CORDIC_STEPS + 20;
    localparam int PHASE_BEATS  = 164;

    logic                      clk;
    logic                      rst_n;
    logic                      sample_valid;
    logic                      sample_stall;
    logic                      data_ready;
    logic signed [RAW_W-1:0]   x_field;
    logic signed [RAW_W-1:0]   y_field;
    logic                      overflow;
    logic                      heading_valid;
    logic                      heading_stall;
    logic [HEADING_W-1:0]      heading_deg;
    logic                      error;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    int                        pending;
    int                        mismatches;
    int                        cycle_count = 0;
    // Calm stretches: no gaps on the sample side, no stalls on the heading side
    logic                      calm = 1'b0;

    magnetometer_heading i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .data_ready    (data_ready),
        .x_field       (x_field),
        .y_field       (y_field),
        .overflow      (overflow),
        .heading_valid (heading_valid),
        .heading_stall (heading_stall),
        .heading_deg   (heading_deg),
        .error         (error),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    heading_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .data_ready    (data_ready),
        .x_field       (x_field),
        .y_field       (y_field),
        .overflow      (overflow),
        .heading_valid (heading_valid),
        .heading_stall (heading_stall),
        .heading_deg   (heading_deg),
        .error         (error),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pending       (pending),
        .mismatches    (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: drop out with a failure if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Axis reading: mostly full-range, some tiny (scale to <= 3), some extremes
    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 16'($urandom);
            6, 7:             return 16'(int'($urandom_range(0, 40)) - 20);
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh7fff;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
            default:          return 16'(int'($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    // Heading side back-pressure: free stretch, then an optional stall stretch.
    // The free stretch is never empty, so stall is never dropped and raised in
    // the same step.
    initial
    begin
        int free_run, hold_run;
        heading_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            free_run = 1 + (calm ? 8 : pick_gap());
            repeat (free_run) @(posedge clk);
            hold_run = calm ? 0 : pick_gap();
            if (hold_run > 0)
            begin
                heading_stall <= 1'b1;
                repeat (hold_run) @(posedge clk);
                heading_stall <= 1'b0;
            end
        end
    end

    // Send one sample beat, after an optional gap; return once it is taken.
    // Valid stays high on return so back-to-back beats need no extra step.
    task automatic send_sample(input logic rdy, input logic signed [15:0] xr,
                               input logic signed [15:0] yr, input logic ovf);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        data_ready   <= rdy;
        x_field      <= xr;
        y_field      <= yr;
        overflow     <= ovf;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    task automatic send_random_sample();
        logic rdy, ovf;
        rdy = ($urandom_range(0, 99) < 88);
        ovf = ($urandom_range(0, 9) == 0);
        send_sample(rdy, pick_axis(), pick_axis(), ovf);
    endtask

    // Drop valid and hold off until every heading due has arrived and the
    // pipeline has had time to empty
    task automatic wait_idle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready
    task automatic write_reg(input reg_idx_t idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int phase_offset, phase_decl;

        sample_valid = 1'b0;
        data_ready   = 1'b0;
        x_field      = '0;
        y_field      = '0;
        overflow     = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        rst_n        = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed beats at the reset register values.
        // Overflow first: it must repeat the cleared held heading.
        send_sample(1'b1, 16'sd500, -16'sd500, 1'b1);
        // No data ready: angle counts as 0, overflow ignored
        send_sample(1'b0, 16'sd1234, 16'sd4321, 1'b0);
        send_sample(1'b0, -16'sd77, 16'sd99, 1'b1);
        // Both axes zero, and axes too small to survive scaling
        send_sample(1'b1, 16'sd0, 16'sd0, 1'b0);
        send_sample(1'b1, 16'sd1, -16'sd1, 1'b0);
        // Extremes; negating the most negative reading wraps onto itself
        send_sample(1'b1, 16'sh7fff, 16'sh7fff, 1'b0);
        send_sample(1'b1, 16'sh8000, 16'sh8000, 1'b0);
        send_sample(1'b1, 16'sh8000, 16'sh7fff, 1'b0);
        send_sample(1'b1, 16'sh7fff, 16'sh8000, 1'b0);
        send_sample(1'b1, 16'sh8000, 16'sh0000, 1'b0);
        send_sample(1'b1, 16'sh0000, 16'sh8000, 1'b0);
        // Four cardinal directions
        send_sample(1'b1, 16'sd1000, 16'sd0, 1'b0);
        send_sample(1'b1, -16'sd1000, 16'sd0, 1'b0);
        send_sample(1'b1, 16'sd0, 16'sd1000, 1'b0);
        send_sample(1'b1, 16'sd0, -16'sd1000, 1'b0);
        // Left half plane, on either side of the scaled y axis sign
        send_sample(1'b1, 16'sd1000, -16'sd3, 1'b0);
        send_sample(1'b1, 16'sd1000, 16'sd10, 1'b0);
        send_sample(1'b1, 16'sd3000, 16'sd2000, 1'b0);
        // Overflow again: now it repeats a non-zero heading
        send_sample(1'b1, 16'sh7fff, 16'sh8000, 1'b1);
        send_sample(1'b1, -16'sd2500, -16'sd1500, 1'b0);

        // Hold the sender until every heading has come back
        wait_idle();

        // Phase 0 keeps the reset registers; then the extremes, zero and
        // random settings in range
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1:
                begin
                    phase_offset = -359;
                    phase_decl   = -23040;
                end
                2:
                begin
                    phase_offset = 359;
                    phase_decl   = 23040;
                end
                3:
                begin
                    phase_offset = 0;
                    phase_decl   = 0;
                end
                default:
                begin
                    phase_offset = int'($urandom_range(0, 718)) - 359;
                    phase_decl   = int'($urandom_range(0, 46080)) - 23040;
                end
            endcase
            if (phase > 0)
            begin
                write_reg(REG_OFFSET, phase_offset);
                write_reg(REG_DECL, phase_decl);
            end
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                // Switch between calm and busy stretches now and then
                if (n % 41 == 0)
                    calm <= ($urandom_range(0, 3) == 0);
                send_random_sample();
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
